// ----- rtl/core/mss_pkg.sv -----
// ----------------------------------------------------------------------------
// mss_pkg
// shared constants, types, sequencer op codes and the sigmoid table of the
// sigmoid network scorer
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int INPUT_COUNT        = 3;
  localparam int HIDDEN_COUNT       = 5;
  localparam int PARAM_COUNT        = 26;
  localparam int SIGMOID_TABLE_BITS = 8;

  localparam int FEATURE_FIELDS = 3;
  localparam int WORD_W         = 16;
  localparam int INDEX_W        = 5;
  localparam int ERR_W          = 30;
  localparam int COUNT_W        = 32;

  localparam int BASE_W = INPUT_COUNT * HIDDEN_COUNT;
  localparam int BASE_R = BASE_W + HIDDEN_COUNT;
  localparam int BASE_O = BASE_R + HIDDEN_COUNT;

  localparam int LAYOUT_W = $clog2(BASE_O + HIDDEN_COUNT + 1);
  localparam int PADDR_W  = $clog2(PARAM_COUNT);
  localparam int SLOT_W   = (LAYOUT_W > PADDR_W) ? LAYOUT_W : PADDR_W;
  localparam int HID_W    = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int IN_W     = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

  localparam int ACC_W  = 34 + $clog2(INPUT_COUNT + HIDDEN_COUNT);
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  localparam int SIG_ENTRIES = 1 << SIGMOID_TABLE_BITS;
  localparam int SIG_HALF    = 1 << (SIGMOID_TABLE_BITS - 1);
  localparam int HID_SHIFT   = 28 - SIGMOID_TABLE_BITS;
  localparam int OUT_SHIFT   = 31 - SIGMOID_TABLE_BITS;

  localparam int HID_THR_SCALE = -(1 << 12);
  localparam int OUT_THR_SCALE = -(1 << 15);

  localparam logic signed [ACC_W-1:0] Q_LOW  = ACC_W'(-SIG_HALF);
  localparam logic signed [ACC_W-1:0] Q_HIGH = ACC_W'(SIG_HALF - 1);

  localparam logic [ERR_W-1:0]   THR_RESET = ERR_W'(1074);
  localparam logic [ERR_W-1:0]   ERR_MAX   = {ERR_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic KIND_SCORE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_EVAL   = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP  = 3'd0;
  localparam logic [OP_W-1:0] OP_HTHR = 3'd1;
  localparam logic [OP_W-1:0] OP_HMAC = 3'd2;
  localparam logic [OP_W-1:0] OP_HSIG = 3'd3;
  localparam logic [OP_W-1:0] OP_OTHR = 3'd4;
  localparam logic [OP_W-1:0] OP_OMAC = 3'd5;
  localparam logic [OP_W-1:0] OP_OSIG = 3'd6;
  localparam logic [OP_W-1:0] OP_ERR  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [HID_W-1:0]  unit;
    logic [IN_W-1:0]   feat;
  } ctrl_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] pred;
    logic [ERR_W-1:0]  he;
  } res_t;

  // e^(-2^j/256) in q0.32
  function automatic logic [63:0] exp_const(input int j);
    logic [63:0] c;
    case (j)
      0:       c = 64'd4278222807;
      1:       c = 64'd4261543595;
      2:       c = 64'd4228377515;
      3:       c = 64'd4162825019;
      4:       c = 64'd4034748382;
      5:       c = 64'd3790295335;
      6:       c = 64'd3344923893;
      7:       c = 64'd2605029347;
      8:       c = 64'd1580030169;
      9:       c = 64'd581260615;
      10:      c = 64'd78665070;
      11:      c = 64'd1440792;
      default: c = 64'd0;
    endcase
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] sig_entry_calc(input int k);
    int          d;
    int          m;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] p;
    d = k - SIG_HALF;
    m = ((d < 0) ? -d : d) << (12 - SIGMOID_TABLE_BITS);
    e = 64'd1 << 32;
    for (int j = 0; j < 12; j++) begin
      if (((m >> j) & 1) != 0) begin
        e = (e * exp_const(j) + (64'd1 << 31)) >> 32;
      end
    end
    den = (64'd1 << 32) + e;
    num = (64'd1 << 47) + (den >> 1);
    r = '0;
    q = '0;
    // restoring long division
    for (int b = 47; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    p = (q > 64'd32768) ? 64'd32768 : q;
    return (d < 0) ? WORD_W'(64'd32768 - p) : WORD_W'(p);
  endfunction

  function automatic logic [SIG_ENTRIES*WORD_W-1:0] sig_table_build();
    logic [SIG_ENTRIES*WORD_W-1:0] t;
    t = '0;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      t[k*WORD_W +: WORD_W] = sig_entry_calc(k);
    end
    return t;
  endfunction

  localparam logic [SIG_ENTRIES*WORD_W-1:0] SIG_TABLE = sig_table_build();

  // q is the pre-activation already scaled to table steps
  function automatic logic [WORD_W-1:0] sig_lookup(input logic signed [ACC_W-1:0] q);
    logic [SIGMOID_TABLE_BITS-1:0] idx;
    if (q < Q_LOW) begin
      idx = '0;
    end else if (q > Q_HIGH) begin
      idx = '1;
    end else begin
      idx = {~q[SIGMOID_TABLE_BITS-1], q[SIGMOID_TABLE_BITS-2:0]};
    end
    return SIG_TABLE[idx*WORD_W +: WORD_W];
  endfunction

endpackage

// ----- rtl/core/mss_seq.sv -----
// ----------------------------------------------------------------------------
// mss_seq
// sequencer that walks the network one multiply-accumulate op per cycle
// ----------------------------------------------------------------------------
module mss_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output mss_pkg::ctrl_t ctrl
);
  import mss_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HTHR = 4'd1;
  localparam logic [3:0] S_HMAC = 4'd2;
  localparam logic [3:0] S_HSIG = 4'd3;
  localparam logic [3:0] S_OTHR = 4'd4;
  localparam logic [3:0] S_OMAC = 4'd5;
  localparam logic [3:0] S_OSIG = 4'd6;
  localparam logic [3:0] S_WAIT = 4'd7;
  localparam logic [3:0] S_ERR  = 4'd8;

  logic [3:0]        state, state_next;
  logic [HID_W-1:0]  unit, unit_next;
  logic [IN_W-1:0]   feat, feat_next;
  logic [SLOT_W-1:0] wslot, wslot_next;

  logic unit_last;
  logic feat_last;

  assign unit_last = (unit == HID_W'(HIDDEN_COUNT - 1));
  assign feat_last = (feat == IN_W'(INPUT_COUNT - 1));

  always_comb begin
    state_next = state;
    unit_next  = unit;
    feat_next  = feat;
    wslot_next = wslot;
    ctrl.op    = OP_NOP;
    ctrl.slot  = '0;
    ctrl.unit  = unit;
    ctrl.feat  = feat;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unit_next  = '0;
          state_next = S_HTHR;
        end
      end
      S_HTHR: begin
        ctrl.op    = OP_HTHR;
        ctrl.slot  = SLOT_W'(BASE_R) + SLOT_W'(unit);
        feat_next  = '0;
        wslot_next = SLOT_W'(unit);
        state_next = S_HMAC;
      end
      S_HMAC: begin
        ctrl.op    = OP_HMAC;
        ctrl.slot  = wslot;
        feat_next  = feat + 1'b1;
        wslot_next = wslot + SLOT_W'(HIDDEN_COUNT);
        if (feat_last) begin
          state_next = S_HSIG;
        end
      end
      S_HSIG: begin
        ctrl.op = OP_HSIG;
        if (unit_last) begin
          unit_next  = '0;
          state_next = S_OTHR;
        end else begin
          unit_next  = unit + 1'b1;
          state_next = S_HTHR;
        end
      end
      S_OTHR: begin
        ctrl.op    = OP_OTHR;
        ctrl.slot  = SLOT_W'(BASE_O);
        state_next = S_OMAC;
      end
      S_OMAC: begin
        ctrl.op   = OP_OMAC;
        ctrl.slot = SLOT_W'(BASE_W) + SLOT_W'(unit);
        unit_next = unit + 1'b1;
        if (unit_last) begin
          state_next = S_OSIG;
        end
      end
      S_OSIG: begin
        ctrl.op    = OP_OSIG;
        state_next = S_WAIT;
      end
      // wait state so that the error op reads the prediction only after the output sigmoid op has written it
      S_WAIT: begin
        state_next = S_ERR;
      end
      S_ERR: begin
        ctrl.op    = OP_ERR;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      unit  <= '0;
      feat  <= '0;
      wslot <= '0;
    end else begin
      state <= state_next;
      unit  <= unit_next;
      feat  <= feat_next;
      wslot <= wslot_next;
    end
  end

endmodule

// ----- rtl/core/mss_datapath.sv -----
// ----------------------------------------------------------------------------
// mss_datapath
// parameter memory, shared 18x18 multiplier, accumulator, sigmoid lookup
// and hidden activation registers
// ----------------------------------------------------------------------------
module mss_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mss_pkg::ctrl_t                    ctrl,
  input  logic                              wr_en,
  input  logic [mss_pkg::PADDR_W-1:0]       wr_addr,
  input  logic [mss_pkg::WORD_W-1:0]        wr_data,
  input  logic signed [mss_pkg::WORD_W-1:0] feat_0,
  input  logic signed [mss_pkg::WORD_W-1:0] feat_1,
  input  logic signed [mss_pkg::WORD_W-1:0] feat_2,
  input  logic [mss_pkg::WORD_W-1:0]        target,
  output mss_pkg::res_t                     res
);
  import mss_pkg::*;

  logic [WORD_W-1:0] mem [PARAM_COUNT];
  logic [WORD_W-1:0] rd_word;

  ctrl_t ctrl1;
  ctrl_t ctrl2;
  logic  slot_ok1;

  logic signed [MUL_W-1:0]  param_ext;
  logic signed [MUL_W-1:0]  feat_sel;
  logic signed [MUL_W-1:0]  diff;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic signed [WORD_W-1:0] feats [FEATURE_FIELDS];
  logic [WORD_W-1:0]        hidden [HIDDEN_COUNT];
  logic [WORD_W-1:0]        pred;

  logic [PROD_W-2:0] he_full;
  logic [ERR_W-1:0]  he_sat;

  // parameter memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word <= mem[ctrl.slot[PADDR_W-1:0]];
  end

  assign feats[0] = feat_0;
  assign feats[1] = feat_1;
  assign feats[2] = feat_2;

  always_comb begin
    param_ext = slot_ok1 ? {{(MUL_W-WORD_W){rd_word[WORD_W-1]}}, rd_word} : '0;
    feat_sel  = '0;
    for (int k = 0; k < FEATURE_FIELDS; k++) begin
      if (int'(ctrl1.feat) == k) begin
        feat_sel = MUL_W'(feats[k]);
      end
    end
    diff = $signed({2'b00, pred}) - $signed({2'b00, target});
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl1.op)
      OP_HTHR: begin
        mul_a = param_ext;
        mul_b = MUL_W'(HID_THR_SCALE);
      end
      OP_HMAC: begin
        mul_a = param_ext;
        mul_b = feat_sel;
      end
      OP_OTHR: begin
        mul_a = param_ext;
        mul_b = MUL_W'(OUT_THR_SCALE);
      end
      OP_OMAC: begin
        mul_a = param_ext;
        mul_b = $signed({2'b00, hidden[ctrl1.unit]});
      end
      OP_ERR: begin
        mul_a = diff;
        mul_b = diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product stage
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign he_full = prod[PROD_W-1:1];
  assign he_sat  = (he_full > (PROD_W-1)'(ERR_MAX)) ? ERR_MAX : he_full[ERR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1.op <= OP_NOP;
      ctrl2.op <= OP_NOP;
      res.done <= 1'b0;
    end else begin
      ctrl1    <= ctrl;
      slot_ok1 <= (ctrl.slot < SLOT_W'(PARAM_COUNT));
      ctrl2    <= ctrl1;
      res.done <= 1'b0;
      unique case (ctrl2.op) inside
        OP_HTHR, OP_OTHR: begin
          acc <= ACC_W'(prod);
        end
        OP_HMAC, OP_OMAC: begin
          acc <= acc + ACC_W'(prod);
        end
        OP_HSIG: begin
          hidden[ctrl2.unit] <= sig_lookup(acc >>> HID_SHIFT);
        end
        OP_OSIG: begin
          pred <= sig_lookup(acc >>> OUT_SHIFT);
        end
        OP_ERR: begin
          res.done <= 1'b1;
          res.pred <= pred;
          res.he   <= he_sat;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/mlp_sigmoid_forward_scorer.sv -----
// ----------------------------------------------------------------------------
// mlp_sigmoid_forward_scorer
// scores a small sigmoid network on a stream of samples and keeps
// saturating sample and hit counts
// ----------------------------------------------------------------------------
// A load request (opcode 0) and a report request (opcode 2) never set busy;
// a report leaves its result in the output register at once. An evaluate
// request (opcode 1) runs through one shared 18x18 multiply-accumulate unit,
// one op per cycle: per hidden unit a threshold op, one op per input and a
// table lookup, then the output threshold, one op per hidden unit, the output
// lookup and the squared error. With 3 inputs and 5 hidden units that is 33
// ops and a wait state for the prediction, plus the memory-read and multiply
// stages and the result register; in_ready stays low until the score is in
// the output register.
// A request is taken only while the output register is empty or being read.
module mlp_sigmoid_forward_scorer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mss_pkg::ERR_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         opcode,
  input  logic [mss_pkg::INDEX_W-1:0]        param_index,
  input  logic signed [mss_pkg::WORD_W-1:0]  param_value,
  input  logic signed [mss_pkg::WORD_W-1:0]  feature_0,
  input  logic signed [mss_pkg::WORD_W-1:0]  feature_1,
  input  logic signed [mss_pkg::WORD_W-1:0]  feature_2,
  input  logic [mss_pkg::WORD_W-1:0]         target,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               result_kind,
  output logic [mss_pkg::WORD_W-1:0]         prediction,
  output logic [mss_pkg::ERR_W-1:0]          half_error,
  output logic                               hit,
  output logic [mss_pkg::COUNT_W-1:0]        samples_seen,
  output logic [mss_pkg::COUNT_W-1:0]        hits_seen
);
  import mss_pkg::*;

  logic busy;
  logic [ERR_W-1:0]   thr;
  logic [COUNT_W-1:0] sample_count;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] sample_count_next;
  logic [COUNT_W-1:0] hit_count_next;

  logic signed [WORD_W-1:0] feat_0;
  logic signed [WORD_W-1:0] feat_1;
  logic signed [WORD_W-1:0] feat_2;
  logic [WORD_W-1:0]        tgt;

  logic accept;
  logic start;
  logic wr_en;
  logic [PADDR_W+INDEX_W-1:0] index_ext;
  logic hit_now;

  ctrl_t ctrl;
  res_t  res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign start     = accept && (opcode == CMD_EVAL);
  assign index_ext = {{PADDR_W{1'b0}}, param_index};
  assign wr_en     = accept && (opcode == CMD_LOAD)
                     && (index_ext < (PADDR_W+INDEX_W)'(PARAM_COUNT));

  assign hit_now = (res.he < thr);
  assign sample_count_next = (sample_count == COUNT_MAX) ? sample_count : sample_count + 1'b1;
  assign hit_count_next    = (hit_now && (hit_count != COUNT_MAX)) ? hit_count + 1'b1
                                                                     : hit_count;

  mss_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctrl  (ctrl)
  );

  mss_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .wr_en   (wr_en),
    .wr_addr (index_ext[PADDR_W-1:0]),
    .wr_data (param_value),
    .feat_0  (feat_0),
    .feat_1  (feat_1),
    .feat_2  (feat_2),
    .target  (tgt),
    .res     (res)
  );

  // sample latch
  always_ff @(posedge clk) begin
    if (start) begin
      feat_0 <= feature_0;
      feat_1 <= feature_1;
      feat_2 <= feature_2;
      tgt    <= target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      out_valid    <= 1'b0;
      thr          <= THR_RESET;
      sample_count <= '0;
      hit_count    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        unique case (opcode)
          CMD_EVAL: begin
            busy <= 1'b1;
          end
          CMD_REPORT: begin
            out_valid    <= 1'b1;
            sample_count <= '0;
            hit_count    <= '0;
          end
          default: begin
          end
        endcase
      end
      if (res.done) begin
        busy         <= 1'b0;
        out_valid    <= 1'b1;
        sample_count <= sample_count_next;
        hit_count    <= hit_count_next;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept && (opcode == CMD_REPORT)) begin
      result_kind  <= KIND_REPORT;
      prediction   <= '0;
      half_error   <= '0;
      hit          <= 1'b0;
      samples_seen <= sample_count;
      hits_seen    <= hit_count;
    end else if (res.done) begin
      result_kind  <= KIND_SCORE;
      prediction   <= res.pred;
      half_error   <= res.he;
      hit          <= hit_now;
      samples_seen <= sample_count_next;
      hits_seen    <= hit_count_next;
    end
  end

endmodule

// ----- rtl/core/mss_checker.sv -----
// ----------------------------------------------------------------------------
// mss_checker
// port-level checks of the sigmoid network scorer, bound to the top level
// ----------------------------------------------------------------------------
module mss_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [1:0]                         opcode,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               result_kind,
  input logic [mss_pkg::WORD_W-1:0]         prediction,
  input logic [mss_pkg::ERR_W-1:0]          half_error,
  input logic                               hit,
  input logic [mss_pkg::COUNT_W-1:0]        samples_seen,
  input logic [mss_pkg::COUNT_W-1:0]        hits_seen
);
  import mss_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prediction) && $stable(half_error)
      && $stable(samples_seen) && $stable(hits_seen))
    else $error("stalled result changed");

  // an evaluate request blocks the next request
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == CMD_EVAL |=> !in_ready)
    else $error("request taken while a sample is scored");

  // a count report carries no score
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_REPORT |-> prediction == '0 && half_error == '0 && !hit)
    else $error("report carries score fields");

  // hits never outnumber samples, and a hit is counted
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_SCORE |-> hits_seen <= samples_seen && samples_seen != '0
      && (!hit || hits_seen != '0))
    else $error("score counts inconsistent");

endmodule

bind mlp_sigmoid_forward_scorer mss_checker u_mss_checker (.*);
